>>> rtl/kscan_pkg.sv
// ----------------------------------------------------------------------------
// kscan_pkg
// Types and register indexes shared by the key scan debounce / repeat block.
// ----------------------------------------------------------------------------
`default_nettype none

package kscan_pkg;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_KEYS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_MS    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CONTINUE_KEY = 2'd3;

    localparam logic [7:0]  RST_NUM_KEYS     = 8'd10;
    localparam logic [15:0] RST_DEBOUNCE_MS  = 16'd20;
    localparam logic [15:0] RST_REPEAT_MS    = 16'd300;
    localparam logic        RST_CONTINUE_KEY = 1'b0;

    typedef struct packed {
        logic        key_sensed;
        logic [15:0] now_ms;
    } sample_t;

    typedef struct packed {
        logic       key_valid;
        logic [7:0] key_id;
        logic       reset_counter;
        logic       pass_done;
    } report_t;

    typedef struct packed {
        logic [7:0]  num_keys;
        logic [15:0] debounce_ms;
        logic [15:0] repeat_ms;
        logic        continue_after_key;
    } cfg_t;

endpackage

`default_nettype wire

>>> rtl/kscan_step.sv
// ----------------------------------------------------------------------------
// kscan_step
// Scan position and per-key debounce / auto-repeat machine; computes one
// report from one sample and updates the state when the sample advances.
// ----------------------------------------------------------------------------
`default_nettype none

module kscan_step (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             advance,
    input  wire kscan_pkg::cfg_t     cfg,
    input  wire kscan_pkg::sample_t  smp,
    output kscan_pkg::report_t    res
);
    import kscan_pkg::*;

    localparam logic [1:0] PH_FIRST    = 2'd0;
    localparam logic [1:0] PH_DEBOUNCE = 2'd1;
    localparam logic [1:0] PH_REPEAT   = 2'd2;
    localparam logic [1:0] PH_SPARE    = 2'd3;

    logic [7:0]  scan_pos_reg,  scan_pos_next;
    logic [1:0]  phase_reg,     phase_next;
    logic [7:0]  held_key_reg,  held_key_next;
    logic [15:0] time_mark_reg, time_mark_next;

    logic [1:0]  phase_eff;
    logic [15:0] elapsed;
    logic [8:0]  pos_inc;
    logic        last;
    logic        report;
    logic        to_zero;

    always_comb
    begin
        phase_eff      = (scan_pos_reg != held_key_reg) ? PH_FIRST : phase_reg;
        elapsed        = smp.now_ms - time_mark_reg;
        pos_inc        = {1'b0, scan_pos_reg} + 9'd1;
        last           = pos_inc >= {1'b0, cfg.num_keys};
        report         = 1'b0;
        phase_next     = phase_reg;
        held_key_next  = held_key_reg;
        time_mark_next = time_mark_reg;

        if (smp.key_sensed)
        begin
            case (phase_eff)
                PH_FIRST:
                begin
                    phase_next     = PH_DEBOUNCE;
                    time_mark_next = smp.now_ms;
                    held_key_next  = scan_pos_reg;
                    report         = 1'b1;
                end
                PH_DEBOUNCE:
                begin
                    if (elapsed >= cfg.debounce_ms)
                    begin
                        phase_next     = PH_REPEAT;
                        time_mark_next = smp.now_ms;
                    end
                end
                PH_REPEAT:
                begin
                    if (elapsed >= cfg.repeat_ms)
                    begin
                        time_mark_next = smp.now_ms;
                        report         = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PH_FIRST;
                    report     = 1'b1;
                end
            endcase
        end

        to_zero       = last || (report && !cfg.continue_after_key);
        scan_pos_next = to_zero ? 8'd0 : pos_inc[7:0];

        res.key_valid     = report;
        res.key_id        = report ? scan_pos_reg : 8'd0;
        res.reset_counter = to_zero;
        res.pass_done     = last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_pos_reg  <= 8'd0;
            phase_reg     <= PH_FIRST;
            held_key_reg  <= 8'd0;
            time_mark_reg <= 16'd0;
        end
        else if (advance)
        begin
            scan_pos_reg  <= scan_pos_next;
            phase_reg     <= phase_next;
            held_key_reg  <= held_key_next;
            time_mark_reg <= time_mark_next;
        end
    end

    // spare phase is never entered from reset
    a_no_spare_phase: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != PH_SPARE)
        else $error("kscan_step: spare phase reached");

    // end of pass always lands on position zero
    a_pass_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        advance && last |=> scan_pos_reg == 8'd0)
        else $error("kscan_step: scan position did not wrap");

    // a first detection locks the machine onto the reported position
    a_first_locks: assert property (@(posedge clk) disable iff (!rst_n)
        advance && smp.key_sensed && phase_eff == PH_FIRST
        |=> phase_reg == PH_DEBOUNCE && held_key_reg == $past(scan_pos_reg))
        else $error("kscan_step: first detection did not arm debounce");

endmodule

`default_nettype wire

>>> rtl/key_scan_debounce_repeat.sv
// ----------------------------------------------------------------------------
// key_scan_debounce_repeat
// Decade-counter key scanner with debounce and auto-repeat reporting.
// ----------------------------------------------------------------------------
// a sample waits in the input register, then its report in the report register
// throughput: one sample per cycle while reports are taken; the input register
//   and report register let the next sample in while a report waits to be taken
// reset: scan position, phase, held key and time mark clear to zero;
//   registers load num_keys 10, debounce 20 ms, repeat 300 ms, restart at zero
`default_nettype none

module key_scan_debounce_repeat (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               sample_valid,
    output logic                                    sample_ready,
    input  wire kscan_pkg::sample_t                 sample,
    output logic                                    report_valid,
    input  wire logic                               report_ready,
    output kscan_pkg::report_t                      report,
    input  wire logic                               cfg_we,
    input  wire logic [kscan_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [kscan_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import kscan_pkg::*;

    cfg_t       cfg_reg;
    logic       in_valid_reg, in_valid_next;
    sample_t    in_data_reg;
    logic       out_valid_reg, out_valid_next;
    report_t    out_data_reg;
    report_t    step_res;
    logic       advance;
    logic       take_in;

    always_comb
    begin
        advance        = in_valid_reg && (!out_valid_reg || report_ready);
        sample_ready   = !in_valid_reg || advance;
        take_in        = sample_valid && sample_ready;
        in_valid_next  = take_in ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = advance ? 1'b1 : (report_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            in_data_reg <= sample;
        end
        if (advance)
        begin
            out_data_reg <= step_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.num_keys           <= RST_NUM_KEYS;
            cfg_reg.debounce_ms        <= RST_DEBOUNCE_MS;
            cfg_reg.repeat_ms          <= RST_REPEAT_MS;
            cfg_reg.continue_after_key <= RST_CONTINUE_KEY;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_NUM_KEYS:     cfg_reg.num_keys           <= cfg_data[7:0];
                REG_DEBOUNCE_MS:  cfg_reg.debounce_ms        <= cfg_data[15:0];
                REG_REPEAT_MS:    cfg_reg.repeat_ms          <= cfg_data[15:0];
                REG_CONTINUE_KEY: cfg_reg.continue_after_key <= cfg_data[0];
                default:          cfg_reg                    <= cfg_reg;
            endcase
        end
    end

    kscan_step u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .cfg     (cfg_reg),
        .smp     (in_data_reg),
        .res     (step_res)
    );

    assign report_valid = out_valid_reg;
    assign report       = out_data_reg;

    // a held sample stays in the input register while the report side stalls
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_data_reg))
        else $error("kscan: input register lost a stalled sample");

    // without continue, every report sends the counter back to zero
    a_report_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        advance && step_res.key_valid && !cfg_reg.continue_after_key
        |=> report.reset_counter)
        else $error("kscan: report without counter reset");

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the key scan debounce / repeat block: a short
// scripted run, then randomized key holds checked against a scan predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import kscan_pkg::*;

    localparam int SCRIPT_LEN  = 25;
    localparam int N_PHASES    = 10;
    localparam int STALL_LIMIT = 2000;
    localparam int LONG_HOLD   = 80;

    typedef enum logic [1:0] {PH_FIRST, PH_DEBOUNCE, PH_REPEAT, PH_SPARE} scan_phase_t;

    typedef struct {
        logic                 is_reg;
        logic [CFG_IDX_W-1:0] idx;
        logic [15:0]          val;
        sample_t              smp;
        logic                 pinned;
        report_t              want;
    } script_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  sample_valid = 1'b0;
    logic                  sample_ready;
    sample_t               sample = '0;
    logic                  report_valid;
    logic                  report_ready = 1'b0;
    report_t               report;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // scan predictor state and its copy of the registers
    logic [7:0]  pos_q = '0;
    scan_phase_t phase_q = PH_FIRST;
    logic [7:0]  held_q = '0;
    logic [15:0] mark_q = '0;
    logic [7:0]  nk_q = RST_NUM_KEYS;
    logic [15:0] deb_q = RST_DEBOUNCE_MS;
    logic [15:0] rep_q = RST_REPEAT_MS;
    logic        cont_q = RST_CONTINUE_KEY;

    report_t     pending_reports[$];
    int          errors = 0;
    int          quiet_cycles = 0;
    logic        calm = 1'b0;
    logic        rx_hold_req = 1'b0;
    int          tx_odds = 8;
    int          rx_odds = 8;

    script_row_t script [SCRIPT_LEN];

    always #5 clk = ~clk;

    key_scan_debounce_repeat u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .report_valid (report_valid),
        .report_ready (report_ready),
        .report       (report),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    function automatic report_t predict_scan(sample_t s);
        report_t     r;
        logic [7:0]  p;
        logic [15:0] elapsed;
        logic        fire;
        logic        last;
        logic        to_zero;
        p    = pos_q;
        fire = 1'b0;
        last = ({1'b0, p} + 9'd1) >= {1'b0, nk_q};
        if (s.key_sensed)
        begin
            if (p != held_q)
                phase_q = PH_FIRST;
            elapsed = s.now_ms - mark_q;
            case (phase_q)
                PH_FIRST:
                begin
                    phase_q = PH_DEBOUNCE;
                    mark_q  = s.now_ms;
                    held_q  = p;
                    fire    = 1'b1;
                end
                PH_DEBOUNCE:
                begin
                    if (elapsed >= deb_q)
                    begin
                        phase_q = PH_REPEAT;
                        mark_q  = s.now_ms;
                    end
                end
                PH_REPEAT:
                begin
                    if (elapsed >= rep_q)
                    begin
                        mark_q = s.now_ms;
                        fire   = 1'b1;
                    end
                end
                default:
                begin
                    phase_q = PH_FIRST;
                    fire    = 1'b1;
                end
            endcase
        end
        to_zero = last || (fire && !cont_q);
        pos_q   = to_zero ? 8'd0 : p + 8'd1;
        r.key_valid     = fire;
        r.key_id        = fire ? p : 8'd0;
        r.reset_counter = to_zero;
        r.pass_done     = last;
        return r;
    endfunction

    function automatic script_row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        script_row_t row;
        row        = '{default: '0};
        row.is_reg = 1'b1;
        row.idx    = idx;
        row.val    = val;
        return row;
    endfunction

    function automatic script_row_t beat_row(logic sensed, logic [15:0] t);
        script_row_t row;
        row                = '{default: '0};
        row.smp.key_sensed = sensed;
        row.smp.now_ms     = t;
        return row;
    endfunction

    function automatic script_row_t typed_row(logic sensed, logic [15:0] t, report_t w);
        script_row_t row;
        row        = beat_row(sensed, t);
        row.pinned = 1'b1;
        row.want   = w;
        return row;
    endfunction

    function automatic logic [15:0] pick_span(int typical);
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(0, typical));
        endcase
    endfunction

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        end
    endtask

    // one sample beat; the expectation is taken at acceptance
    task automatic send_beat(sample_t s, logic pinned, report_t pinned_rep);
        report_t guess;
        sample_valid <= 1'b1;
        sample       <= s;
        @(posedge clk);
        while (!sample_ready)
            @(posedge clk);
        guess = predict_scan(s);
        pending_reports.push_back(pinned ? pinned_rep : guess);
        if (!calm && $urandom_range(0, tx_odds) == 0)
        begin
            sample_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
    endtask

    task automatic settle();
        sample_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_NUM_KEYS:     nk_q = val[7:0];
            REG_DEBOUNCE_MS:  deb_q = val;
            REG_REPEAT_MS:    rep_q = val;
            REG_CONTINUE_KEY: cont_q = val[0];
            default:          ;
        endcase
        @(posedge clk);
    endtask

    // report side: random stall bursts plus a long hold-off on request
    initial
    begin : report_side
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                hold_left   = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                report_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                report_ready <= 1'b0;
            end
            else if (rst_n && !calm && $urandom_range(0, rx_odds) == 0)
            begin
                stall_left = $urandom_range(0, 8);
                report_ready <= 1'b0;
            end
            else
                report_ready <= rst_n;
        end
    end

    always @(posedge clk)
    begin : check_reports
        report_t head;
        if (rst_n && report_valid && report_ready)
        begin
            if (pending_reports.size() == 0)
            begin
                errors++;
                $display("%0t: report with none expected: expected none got %p", $time, report);
            end
            else
            begin
                head = pending_reports.pop_front();
                check_field("key_valid", 8'(head.key_valid), 8'(report.key_valid));
                check_field("key_id", head.key_id, report.key_id);
                check_field("reset_counter", 8'(head.reset_counter), 8'(report.reset_counter));
                check_field("pass_done", 8'(head.pass_done), 8'(report.pass_done));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (sample_valid && sample_ready) || (report_valid && report_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
            $display("end of test: mismatches");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : stimulus
        sample_t     b;
        logic [15:0] clock_ms;
        logic [15:0] span;
        logic [15:0] step_max;
        logic [7:0]  hk;
        logic        pressed;
        logic [7:0]  nk;
        logic [15:0] deb;
        logic [15:0] rep;
        logic        cont;
        int          n_items;

        script = '{
            typed_row(1'b1, 16'h0000, {1'b1, 8'd0, 1'b1, 1'b0}),
            typed_row(1'b0, 16'h0005, {1'b0, 8'd0, 1'b0, 1'b0}),
            typed_row(1'b1, 16'h000A, {1'b1, 8'd1, 1'b1, 1'b0}),
            reg_row(REG_NUM_KEYS, 16'd1),
            typed_row(1'b1, 16'hFFFF, {1'b1, 8'd0, 1'b1, 1'b1}),
            beat_row(1'b1, 16'h0012),       // one short of debounce across the wrap
            beat_row(1'b0, 16'h8000),       // release leaves the machine alone
            beat_row(1'b1, 16'h0013),
            beat_row(1'b1, 16'h013E),
            beat_row(1'b1, 16'h013F),       // first auto-repeat
            beat_row(1'b0, 16'h7FFF),
            beat_row(1'b1, 16'h013F),
            beat_row(1'b1, 16'h8000),
            reg_row(REG_DEBOUNCE_MS, 16'd0),
            reg_row(REG_REPEAT_MS, 16'd0),
            reg_row(REG_CONTINUE_KEY, 16'd1),
            reg_row(REG_NUM_KEYS, 16'd255),
            beat_row(1'b1, 16'h0000),
            beat_row(1'b1, 16'h0000),
            beat_row(1'b1, 16'hFFFF),
            beat_row(1'b1, 16'h5555),
            reg_row(REG_NUM_KEYS, 16'd0),   // position already past the end
            beat_row(1'b1, 16'h1234),
            beat_row(1'b1, 16'h1234),
            beat_row(1'b0, 16'hAAAA)
        };

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            if (script[i].is_reg)
            begin
                settle();
                write_reg(script[i].idx, script[i].val);
            end
            else
                send_beat(script[i].smp, script[i].pinned, script[i].want);
        end

        clock_ms = 16'd0;
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    nk   = 8'd255;
                    deb  = 16'($urandom_range(0, 30));
                    rep  = 16'($urandom_range(0, 60));
                    cont = 1'b1;
                end
                1:
                begin
                    nk   = 8'd1;
                    deb  = 16'hFFFF;
                    rep  = 16'hFFFF;
                    cont = 1'b0;
                end
                2:
                begin
                    nk   = 8'd4;
                    deb  = 16'd0;
                    rep  = 16'd0;
                    cont = 1'b0;
                end
                default:
                begin
                    case ($urandom_range(0, 5))
                        0:       nk = 8'd1;
                        1:       nk = 8'd2;
                        2:       nk = 8'd255;
                        default: nk = 8'($urandom_range(1, 16));
                    endcase
                    deb  = pick_span(40);
                    rep  = pick_span(400);
                    cont = 1'($urandom_range(0, 1));
                end
            endcase
            settle();
            write_reg(REG_NUM_KEYS, {8'd0, nk});
            write_reg(REG_DEBOUNCE_MS, deb);
            write_reg(REG_REPEAT_MS, rep);
            write_reg(REG_CONTINUE_KEY, {15'd0, cont});

            calm    = (ph >= N_PHASES - 3);
            tx_odds = (ph % 3 == 0) ? 40 : ((ph % 3 == 1) ? 3 : 10);
            rx_odds = (ph % 2 == 0) ? 4 : 30;
            span     = (deb > rep) ? deb : rep;
            step_max = (span >> 3) + 16'd2;
            hk       = (nk == 8'd0) ? 8'd0 : nk - 8'd1;
            pressed  = 1'b1;
            n_items  = (ph == 0) ? 400 : 165;

            for (int i = 0; i < n_items; i++)
            begin
                if (ph == 3 && i == 20)
                    rx_hold_req = 1'b1;
                if (ph == 4 && i == 40)
                    settle();
                if ($urandom_range(0, 29) == 0)
                    pressed = ~pressed;
                if ($urandom_range(0, 49) == 0)
                begin
                    if ($urandom_range(0, 7) == 0)
                        hk = 8'($urandom_range(0, 255));
                    else
                        hk = (nk == 8'd0) ? 8'd0 : 8'($urandom_range(0, nk - 1));
                end
                // land on the debounce and repeat boundaries now and then
                case ($urandom_range(0, 19))
                    0:       clock_ms = 16'($urandom_range(0, 65535));
                    1:       clock_ms = mark_q + deb_q - 16'd1;
                    2:       clock_ms = mark_q + deb_q;
                    3:       clock_ms = mark_q + rep_q - 16'd1;
                    4:       clock_ms = mark_q + rep_q;
                    5:       clock_ms = mark_q - 16'd1;
                    default: clock_ms = clock_ms + 16'($urandom_range(0, step_max));
                endcase
                b.now_ms = clock_ms;
                if ($urandom_range(0, 9) == 0)
                    b.key_sensed = 1'($urandom_range(0, 1));
                else
                    b.key_sensed = pressed && (pos_q == hk);
                send_beat(b, 1'b0, '0);
            end
        end

        calm = 1'b1;
        settle();
        repeat (10) @(posedge clk);
        if (errors == 0 && pending_reports.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
